[design/mbps_pkg.sv]
// Shared types and constants of the masked byte pattern search.
package mbps_pkg;

	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 6;
	localparam int PLEN_W  = 7;
	localparam int SKIP_W  = 16;
	localparam int POS_W   = 32;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SCAN    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LENGTH = 1'b0,
		CFG_SKIP_BYTES     = 1'b1
	} cfg_reg_t;

	// One pattern entry: the byte and its wildcard mark.
	typedef struct packed {
		logic              wild;
		logic [BYTE_W-1:0] value;
	} pat_entry_t;

	// Common control of the pattern cell chain.
	typedef struct packed {
		logic       up;
		logic       dn;
		logic       ld;
		pat_entry_t data;
	} pat_ctrl_t;

endpackage

[design/mbps_if.sv]
// Handshake channel interfaces for the request and result items.
interface mbps_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  op;
	logic [mbps_pkg::IDX_W-1:0]  entry_index;
	logic [mbps_pkg::BYTE_W-1:0] byte_value;
	logic                        is_wildcard;
	logic                        last_byte;

	modport source (output valid, op, entry_index, byte_value, is_wildcard, last_byte,
		input ready);
	modport sink (input valid, op, entry_index, byte_value, is_wildcard, last_byte,
		output ready);
endinterface

interface mbps_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [mbps_pkg::POS_W-1:0] match_position;

	modport source (output valid, found, match_position, input ready);
	modport sink (input valid, found, match_position, output ready);
endinterface

[design/mbps_pat_cell.sv]
// One pattern cell: holds an entry, shifts with its neighbors or takes a load.
module mbps_pat_cell (
	input  logic                 clk,
	input  mbps_pkg::pat_ctrl_t  ctrl,
	input  logic                 sel,
	input  mbps_pkg::pat_entry_t below,
	input  mbps_pkg::pat_entry_t above,
	output mbps_pkg::pat_entry_t entry
);

	mbps_pkg::pat_entry_t entry_q;

	// Realignment moves the whole chain one place; loads write a single cell.
	always_ff @(posedge clk) begin
		if (ctrl.up) begin
			entry_q <= below;
		end else if (ctrl.dn) begin
			entry_q <= above;
		end else if (ctrl.ld && sel) begin
			entry_q <= ctrl.data;
		end
	end

	assign entry = entry_q;

endmodule

[design/mbps_win_cell.sv]
// One window cell: holds a searched byte, passes it on and compares it.
module mbps_win_cell (
	input  logic                          clk,
	input  logic                          shift,
	input  logic [mbps_pkg::BYTE_W-1:0]   din,
	input  mbps_pkg::pat_entry_t          pat,
	output logic [mbps_pkg::BYTE_W-1:0]   dout,
	output logic                          hit
);

	logic [mbps_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	assign hit  = pat.wild | (byte_q == pat.value);

endmodule

[design/masked_byte_pattern_search.sv]
// Masked byte pattern search: streams region bytes through a row of window cells at one
// item per clock, unless a realignment or a waiting result stalls the input, and reports
// the first offset where the loaded pattern (with wildcard entries) matches, or not found
// at the last byte. Load, scan and restart items are all taken back to back. A byte that
// causes a result is registered into the compare stage and then into the output register,
// which drives result.valid. While a result waits to be taken the input keeps flowing
// until a searched byte of the next region reaches the compare stage; that byte then
// holds request.ready low until the waiting result is taken.
// The window is a shift chain of PATTERN_MAX byte cells, each compared in parallel with
// the pattern entry paired to it, so all entries are compared at once, combinationally.
// The pattern lives in a second chain of 2*PATTERN_MAX-1 cells kept aligned to the
// active length; after a write of pattern_length the chain slides one cell per clock,
// so request.ready stays low, from the cycle after the write, until the chain has moved
// from the last nonzero length to the new one (capped at PATTERN_MAX). A zero length
// leaves the chain where it is. Register writes are meant for idle periods: write only
// when the output register is empty and at least one cycle has passed since the last
// item was accepted. No clearing pass is needed after reset.
module masked_byte_pattern_search #(
	parameter int PATTERN_MAX = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mbps_req_if.sink                      request,
	mbps_rsp_if.source                    result,
	input  logic                          cfg_write,
	input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_W-1:0]    cfg_data
);

	localparam int LW     = $clog2(PATTERN_MAX + 1);
	localparam int RCELLS = 2 * PATTERN_MAX - 1;
	localparam int RIW    = (RCELLS > 1) ? $clog2(RCELLS) : 1;

	// Configuration registers.
	logic [mbps_pkg::PLEN_W-1:0] plen_q;
	logic [mbps_pkg::SKIP_W-1:0] skip_q;

	// Scan state.
	logic [LW-1:0]                fill_q;
	logic [mbps_pkg::POS_W-1:0]   count_q;
	logic                         done_q;
	logic [LW-1:0]                align_q;

	// Compare stage: the byte whose window is being checked.
	logic                         valid_s1;
	logic [mbps_pkg::POS_W-1:0]   here_s1;
	logic                         last_s1;
	logic                         counted_s1;

	// Output register.
	logic                         out_valid_q;
	logic                         found_q;
	logic [mbps_pkg::POS_W-1:0]   pos_q;

	logic [31:0]                  len_wide;
	logic [LW-1:0]                len;
	logic                         busy;
	logic                         stall_s1;
	logic                         go_s1;
	logic                         match;
	logic                         res_s1;
	logic                         accept;
	logic                         is_load;
	logic                         is_scan;
	logic                         is_restart;
	logic                         scan_go;
	logic                         counted;
	logic                         shift;
	logic [31:0]                  ld_tgt;
	logic                         ld_go;
	mbps_pkg::pat_ctrl_t          pctrl;
	mbps_pkg::pat_entry_t         rcell [RCELLS];
	logic [mbps_pkg::BYTE_W-1:0]  wcell [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]       hit;
	logic [PATTERN_MAX-1:0]       ok_v;

	// The length in use is the register value, capped at the number of cells.
	always_comb begin
		if (32'(plen_q) > 32'(PATTERN_MAX)) begin
			len_wide = 32'(PATTERN_MAX);
		end else begin
			len_wide = 32'(plen_q);
		end
	end
	assign len = len_wide[LW-1:0];

	// The pattern chain is aligned to align_q; a zero length leaves it where it is.
	assign busy = (len != '0) && (align_q != len);

	// The compare stage holds while its slot in the output register is still taken.
	assign stall_s1 = valid_s1 && out_valid_q && !result.ready;
	assign go_s1    = valid_s1 && !stall_s1;

	assign request.ready = !busy && !stall_s1;
	assign accept        = request.valid && request.ready;

	always_comb begin
		is_load    = 1'b0;
		is_scan    = 1'b0;
		is_restart = 1'b0;
		case (mbps_pkg::op_t'(request.op))
			mbps_pkg::OP_LOAD:    is_load    = 1'b1;
			mbps_pkg::OP_SCAN:    is_scan    = 1'b1;
			mbps_pkg::OP_RESTART: is_restart = 1'b1;
			default: ;
		endcase
	end

	// Window compare of the byte in the compare stage. Cells past the length do not count.
	generate
		for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_ok
			assign ok_v[k] = hit[k] | (32'(k) >= 32'(len));
		end
	endgenerate
	assign match  = (&ok_v) && (len != '0) && (fill_q >= len);
	assign res_s1 = (counted_s1 && match) || last_s1;

	// A byte that follows one that just gave its result is ignored, as is any byte
	// that arrives after the region's result until a restart.
	assign scan_go = accept && is_scan && !done_q && !(go_s1 && res_s1);
	assign counted = count_q >= 32'(skip_q);
	assign shift   = scan_go && counted;

	// A load goes to the pattern cell paired with that entry under the current alignment.
	assign ld_go  = accept && is_load && (32'(request.entry_index) < 32'(PATTERN_MAX));
	assign ld_tgt = 32'(align_q) + 32'(PATTERN_MAX) - 32'd2 - 32'(request.entry_index);

	always_comb begin
		pctrl.up         = busy && (align_q < len);
		pctrl.dn         = busy && (align_q > len);
		pctrl.ld         = ld_go;
		pctrl.data.wild  = request.is_wildcard;
		pctrl.data.value = request.byte_value;
	end

	// Pattern cell m holds the entry with index align_q + PATTERN_MAX - 2 - m.
	generate
		for (genvar m = 0; m < RCELLS; m++) begin : g_pat
			mbps_pkg::pat_entry_t below;
			mbps_pkg::pat_entry_t above;
			if (m == 0) begin : g_lo
				assign below = rcell[m];
			end else begin : g_mid_lo
				assign below = rcell[m-1];
			end
			if (m == RCELLS - 1) begin : g_hi
				assign above = rcell[m];
			end else begin : g_mid_hi
				assign above = rcell[m+1];
			end
			mbps_pat_cell u_cell (
				.clk   (clk),
				.ctrl  (pctrl),
				.sel   (ld_tgt[RIW-1:0] == RIW'(m)),
				.below (below),
				.above (above),
				.entry (rcell[m])
			);
		end
	endgenerate

	// Window cell k holds the k-th most recent searched byte and meets pattern cell
	// k + PATTERN_MAX - 1, which carries entry len - 1 - k once aligned.
	generate
		for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_win
			logic [mbps_pkg::BYTE_W-1:0] din;
			if (k == 0) begin : g_first
				assign din = request.byte_value;
			end else begin : g_rest
				assign din = wcell[k-1];
			end
			mbps_win_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.din   (din),
				.pat   (rcell[k + PATTERN_MAX - 1]),
				.dout  (wcell[k]),
				.hit   (hit[k])
			);
		end
	endgenerate

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= mbps_pkg::PLEN_W'(1);
			skip_q <= '0;
		end else if (cfg_write) begin
			case (mbps_pkg::cfg_reg_t'(cfg_index))
				mbps_pkg::CFG_PATTERN_LENGTH: plen_q <= cfg_data[mbps_pkg::PLEN_W-1:0];
				mbps_pkg::CFG_SKIP_BYTES:     skip_q <= cfg_data[mbps_pkg::SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	// Pattern alignment walks one cell per clock toward the active length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= LW'(1);
		end else if (pctrl.up) begin
			align_q <= align_q + LW'(1);
		end else if (pctrl.dn) begin
			align_q <= align_q - LW'(1);
		end
	end

	// Region counters and the result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else if (accept && is_restart) begin
			fill_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (scan_go && (count_q != '1)) begin
				count_q <= count_q + 32'd1;
			end
			if (shift && (32'(fill_q) < 32'(PATTERN_MAX))) begin
				fill_q <= fill_q + LW'(1);
			end
			if (go_s1 && res_s1) begin
				done_q <= 1'b1;
			end
		end
	end

	// Compare stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_go) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go) begin
			here_s1    <= count_q;
			last_s1    <= request.last_byte;
			counted_s1 <= counted;
		end
	end

	// Output register: a match wins over the end of the region.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_s1) begin
			found_q <= counted_s1 && match;
			if (counted_s1 && match) begin
				pos_q <= here_s1 - (32'(len) - 32'd1);
			end else begin
				pos_q <= '0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.found          = found_q;
	assign result.match_position = pos_q;

	// No item may enter while the pattern chain is still sliding.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !request.ready)
		else $error("item accepted while pattern chain realigns");

	// The window fill count saturates at the number of cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(PATTERN_MAX))
		else $error("window fill count out of range");

	// A stalled compare stage keeps its byte for the next cycle.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall_s1 |=> valid_s1 && $stable(here_s1))
		else $error("compare stage lost its byte during a stall");

	// The scan counter only moves when a searched byte is taken or a restart occurs.
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("byte counter changed without an item");

endmodule

[tb/sv/mbps_search_checker.sv]
`timescale 1ns / 1ps
// Checker for the masked byte pattern search: predicts every result and compares it.
module mbps_search_checker #(
	parameter int PATTERN_MAX = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mbps_req_if                            request,
	mbps_rsp_if                            result,
	input  logic                           cfg_write,
	input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_W-1:0]     cfg_data,
	output int                             fail_count,
	output int                             outstanding,
	output int                             results_checked,
	output int                             matches_checked
);
	import mbps_pkg::*;

	typedef struct {
		logic             found;
		logic [POS_W-1:0] position;
	} search_outcome_t;

	search_outcome_t awaited_outcomes[$];
	search_outcome_t oldest;

	logic [BYTE_W-1:0] sig_bytes [PATTERN_MAX];
	logic              sig_wild [PATTERN_MAX];
	logic [BYTE_W-1:0] recent_bytes [PATTERN_MAX];
	int unsigned       recent_fill;
	logic [POS_W-1:0]  region_offset;
	logic              region_closed;
	logic [PLEN_W-1:0] cur_length;
	logic [SKIP_W-1:0] cur_skip;

	// The newest byte sits at index 0, so pattern entry i lines up with window entry len-1-i.
	function automatic bit window_hits(int unsigned len);
		if (len == 0 || recent_fill < len)
			return 1'b0;
		for (int i = 0; i < len; i++) begin
			if (!sig_wild[i] && recent_bytes[len - 1 - i] != sig_bytes[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic clear_region();
		for (int i = 0; i < PATTERN_MAX; i++)
			recent_bytes[i] = '0;
		recent_fill = 0;
		region_offset = '0;
		region_closed = 1'b0;
	endtask

	task automatic predict_scan_byte(input logic [BYTE_W-1:0] value, input logic last);
		logic [POS_W-1:0] here;
		int unsigned      len;
		bit               hit;
		if (region_closed)
			return;
		here = region_offset;
		if (region_offset != '1)
			region_offset++;
		hit = 1'b0;
		if (here >= cur_skip) begin
			for (int i = PATTERN_MAX - 1; i > 0; i--)
				recent_bytes[i] = recent_bytes[i - 1];
			recent_bytes[0] = value;
			if (recent_fill < PATTERN_MAX)
				recent_fill++;
			len = (cur_length > PATTERN_MAX) ? PATTERN_MAX : cur_length;
			hit = window_hits(len);
			if (hit) begin
				region_closed = 1'b1;
				awaited_outcomes.insert(awaited_outcomes.size(),
					search_outcome_t'{1'b1, here - POS_W'(len - 1)});
			end
		end
		if (!hit && last) begin
			region_closed = 1'b1;
			awaited_outcomes.insert(awaited_outcomes.size(), search_outcome_t'{1'b0, '0});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				sig_bytes[i] = '0;
				sig_wild[i] = 1'b0;
			end
			clear_region();
			cur_length = PLEN_W'(1);
			cur_skip = '0;
			awaited_outcomes.delete();
			fail_count = 0;
			results_checked = 0;
			matches_checked = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PATTERN_LENGTH: cur_length = cfg_data[PLEN_W-1:0];
					CFG_SKIP_BYTES:     cur_skip = cfg_data[SKIP_W-1:0];
					default: ;
				endcase
			end
			if (request.valid && request.ready) begin
				case (op_t'(request.op))
					OP_LOAD: begin
						sig_bytes[request.entry_index] = request.byte_value;
						sig_wild[request.entry_index] = request.is_wildcard;
					end
					OP_SCAN:    predict_scan_byte(request.byte_value, request.last_byte);
					OP_RESTART: clear_region();
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (awaited_outcomes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
						$time, result.found, result.match_position);
				end else begin
					oldest = awaited_outcomes.pop_front();
					results_checked++;
					if (oldest.found)
						matches_checked++;
					if (result.found !== oldest.found) begin
						fail_count++;
						$display("%0t: found mismatch, expected %0b, actual %0b",
							$time, oldest.found, result.found);
					end
					if (result.match_position !== oldest.position) begin
						fail_count++;
						$display("%0t: match_position mismatch, expected %0d, actual %0d",
							$time, oldest.position, result.match_position);
					end
				end
			end
		end
		outstanding = awaited_outcomes.size();
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the masked byte pattern search: clock, reset, stimulus and verdict.
module tb;
	import mbps_pkg::*;

	localparam int PATTERN_MAX     = 64;
	localparam int RUN_LIMIT       = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_CYCLES    = 4;
	localparam int RANDOM_ITEMS    = 850;
	// Op code 3 has no meaning; the block must drop such items without a result.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {
		TAKE_ALWAYS,
		TAKE_COIN,
		TAKE_SPARSE,
		TAKE_PERIODIC
	} take_style_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	mbps_req_if request();
	mbps_rsp_if result();

	int fail_count;
	int outstanding;
	int results_checked;
	int matches_checked;

	int cycle_count;
	int items_sent;
	int burst_left;
	int hold_off_asked;
	int hold_off_done;
	bit sender_idles;
	int cur_len;
	int cur_skip;

	// Our own view of the loaded pattern, used only to plant matches in generated regions.
	logic [BYTE_W-1:0] sig_shadow [PATTERN_MAX];
	logic              wild_shadow [PATTERN_MAX];
	logic [BYTE_W-1:0] region_buf[$];

	masked_byte_pattern_search #(
		.PATTERN_MAX(PATTERN_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.result   (result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	mbps_search_checker #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.request        (request),
		.result         (result),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.matches_checked(matches_checked)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// The whole run is bounded by a plain cycle count. Reaching it means something hung.
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results still awaited.",
			cycle_count, outstanding);
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side. The ready pattern switches at random among four styles so that stalls
	// land on every phase of the block's pipeline. When the stimulus asks for a hold-off,
	// ready stays low for a long stretch counted here, which backs results up into the
	// block until it has to stall its input.
	initial begin
		take_style_t style;
		int          style_left;
		int          held;
		int          tick;
		result.ready = 1'b0;
		style = TAKE_ALWAYS;
		style_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_off_asked != hold_off_done) begin
				result.ready <= 1'b0;
				held = 0;
				while (held < HOLD_OFF_CYCLES) begin
					@(negedge clk);
					held++;
				end
				hold_off_done++;
			end else begin
				if (style_left == 0) begin
					style = take_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(20, 200);
				end
				style_left--;
				case (style)
					TAKE_ALWAYS: result.ready <= 1'b1;
					TAKE_COIN:   result.ready <= 1'($urandom_range(0, 1));
					TAKE_SPARSE: result.ready <= ($urandom_range(0, 3) == 0);
					default:     result.ready <= ((tick % 7) < 4);
				endcase
			end
		end
	end

	// Offers one item and returns at the falling edge after it was accepted. The sender
	// works in bursts; between bursts it may drop valid for a random gap. Valid is never
	// lowered here at the end of an item, so back-to-back items keep it high.
	task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
		input logic [BYTE_W-1:0] value, input logic wild, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!sender_idles)
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(6, 20);
			else
				gap = $urandom_range(0, 3);
			if (gap != 0) begin
				request.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		request.valid <= 1'b1;
		request.op <= op;
		request.entry_index <= idx;
		request.byte_value <= value;
		request.is_wildcard <= wild;
		request.last_byte <= last;
		@(posedge clk);
		while (request.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Fields that an op does not use get random values, so the block must ignore them.
	task automatic load_entry(input int idx, input logic [BYTE_W-1:0] value, input logic wild);
		sig_shadow[idx] = value;
		wild_shadow[idx] = wild;
		send_item(OP_LOAD, IDX_W'(idx), value, wild, 1'($urandom_range(0, 1)));
	endtask

	task automatic scan_byte(input logic [BYTE_W-1:0] value, input logic last);
		send_item(OP_SCAN, IDX_W'($urandom), value, 1'($urandom_range(0, 1)), last);
	endtask

	task automatic restart_region();
		send_item(OP_RESTART, IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic send_noise();
		send_item(OP_UNUSED, IDX_W'($urandom), BYTE_W'($urandom), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// Stops offering items until every predicted result has been taken, then leaves the
	// block idle for QUIET_CYCLES, since a byte that causes no result may still be in flight.
	task automatic drain();
		request.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// Both registers are written on consecutive edges while the block is idle.
	task automatic set_config(input int plen, input int skip);
		drain();
		cur_len = plen;
		cur_skip = skip;
		cfg_write <= 1'b1;
		cfg_index <= CFG_PATTERN_LENGTH;
		cfg_data <= CFG_W'(plen);
		@(negedge clk);
		cfg_index <= CFG_SKIP_BYTES;
		cfg_data <= CFG_W'(skip);
		@(negedge clk);
		cfg_write <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// One region: bytes are drawn half from the active pattern, so partial matches are
	// common, and most regions get the whole pattern planted after the skipped part. A
	// messy region also carries pattern reloads, dead op codes and stray restarts, and
	// about one region in ten never marks its final byte as last.
	task automatic play_region(input bit messy);
		int unsigned act;
		int unsigned n;
		int unsigned at;
		bit          close_it;
		act = (cur_len > PATTERN_MAX) ? PATTERN_MAX : cur_len;
		n = cur_skip + $urandom_range(1, act + 24);
		region_buf.delete();
		for (int i = 0; i < n; i++) begin
			if (act != 0 && $urandom_range(0, 1) == 1)
				region_buf.insert(region_buf.size(), sig_shadow[$urandom_range(0, act - 1)]);
			else
				region_buf.insert(region_buf.size(), BYTE_W'($urandom));
		end
		if (act != 0 && n >= cur_skip + act && $urandom_range(0, 9) < 7) begin
			at = $urandom_range(cur_skip, n - act);
			for (int i = 0; i < act; i++)
				region_buf[at + i] = wild_shadow[i] ? BYTE_W'($urandom) : sig_shadow[i];
		end
		close_it = ($urandom_range(0, 9) != 0);
		restart_region();
		for (int i = 0; i < n; i++) begin
			if (messy) begin
				case ($urandom_range(0, 49))
					0: load_entry($urandom_range(0, PATTERN_MAX - 1), BYTE_W'($urandom),
						$urandom_range(0, 4) == 0);
					1: send_noise();
					2: restart_region();
					default: ;
				endcase
			end
			scan_byte(region_buf[i], close_it && (i == n - 1));
		end
	endtask

	initial begin
		int goal;
		int phase;
		int pick;
		int plen;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_PATTERN_LENGTH;
		cfg_data = '0;
		request.valid = 1'b0;
		request.op = OP_LOAD;
		request.entry_index = '0;
		request.byte_value = '0;
		request.is_wildcard = 1'b0;
		request.last_byte = 1'b0;
		items_sent = 0;
		burst_left = 0;
		hold_off_asked = 0;
		hold_off_done = 0;
		sender_idles = 1'b1;
		cur_len = 1;
		cur_skip = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Every pattern entry is loaded once up front, so no compare ever touches an entry
		// that was never written, whatever length a later phase selects.
		for (int i = 0; i < PATTERN_MAX; i++)
			load_entry(i, BYTE_W'($urandom), 1'($urandom_range(0, 1)));

		// Directed part. A three-entry pattern with extreme bytes and a wildcard in the
		// middle matches at the region start; bytes after that result are dropped, as is
		// an item with the unused op code.
		set_config(3, 0);
		load_entry(0, 8'h00, 1'b0);
		load_entry(1, 8'h5A, 1'b1);
		load_entry(2, 8'hFF, 1'b0);
		restart_region();
		scan_byte(8'h00, 1'b0);
		scan_byte(8'hC3, 1'b0);
		scan_byte(8'hFF, 1'b0);
		scan_byte(8'h00, 1'b1);
		send_noise();
		// The match completes on the final byte of the region, so found must win.
		restart_region();
		scan_byte(8'hFF, 1'b0);
		scan_byte(8'h00, 1'b0);
		scan_byte(8'h00, 1'b0);
		scan_byte(8'hFF, 1'b1);
		// A region that ends without a match.
		restart_region();
		scan_byte(8'h00, 1'b0);
		scan_byte(8'hFF, 1'b1);
		// With two skipped bytes: first the region ends inside the skipped part, then a
		// match right after it reports its offset from the true region start.
		set_config(3, 2);
		restart_region();
		scan_byte(8'h00, 1'b0);
		scan_byte(8'h00, 1'b1);
		restart_region();
		scan_byte(8'h00, 1'b0);
		scan_byte(8'hFF, 1'b0);
		scan_byte(8'h00, 1'b0);
		scan_byte(8'h11, 1'b0);
		scan_byte(8'hFF, 1'b1);
		// Length zero never matches, but the region end still reports not found.
		set_config(0, 0);
		restart_region();
		scan_byte(8'h00, 1'b1);
		// Pattern reloads in the middle of a region apply to the next byte, and a length
		// change between bytes keeps the window that was already collected.
		set_config(2, 0);
		restart_region();
		scan_byte(8'h77, 1'b0);
		load_entry(0, 8'h77, 1'b0);
		load_entry(1, 8'h88, 1'b0);
		scan_byte(8'h88, 1'b0);
		restart_region();
		scan_byte(8'h88, 1'b0);
		scan_byte(8'h12, 1'b0);
		set_config(1, 0);
		scan_byte(8'h77, 1'b1);

		// Back pressure: the receiver holds off for a long stretch while short regions,
		// each giving a result, keep coming with no gaps, so the block has to stall.
		sender_idles = 1'b0;
		hold_off_asked++;
		repeat (40) begin
			restart_region();
			scan_byte(BYTE_W'($urandom), 1'b0);
			scan_byte(BYTE_W'($urandom), 1'b1);
		end

		// The largest skip: a short region ends deep inside the skipped part, so it
		// reports not found.
		sender_idles = 1'b1;
		set_config(2, 65535);
		load_entry(0, BYTE_W'($urandom), 1'b0);
		load_entry(1, BYTE_W'($urandom), 1'b1);
		restart_region();
		repeat (5) scan_byte(BYTE_W'($urandom), 1'b0);
		scan_byte(BYTE_W'($urandom), 1'b1);

		// Random phases. The first two use the full length and a length beyond the
		// pattern store; later ones mostly use short patterns with occasional long ones.
		goal = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 19);
			if (phase == 0)
				plen = PATTERN_MAX;
			else if (phase == 1)
				plen = 127;
			else if (pick == 0)
				plen = 0;
			else if (pick == 1)
				plen = $urandom_range(PATTERN_MAX + 1, 127);
			else if (pick < 5)
				plen = $urandom_range(9, 40);
			else
				plen = $urandom_range(1, 8);
			set_config(plen, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0);
			sender_idles = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < plen && i < PATTERN_MAX; i++)
				load_entry(i, BYTE_W'($urandom), $urandom_range(0, 4) == 0);
			repeat ($urandom_range(3, 8)) play_region(1'b1);
			phase++;
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d items over %0d random phases; checked %0d results (%0d found, %0d not found).",
			items_sent, phase, results_checked, matches_checked,
			results_checked - matches_checked);
		$display("Lengths 0 to 127, skips 0 to 65535, a long result hold-off and mid-region reloads.");
		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
